[rtl/nsr_pkg.sv]
// Shared widths, micro-operation codes and the microcode program of the square-root unit.
package nsr_pkg;

    localparam int RAD_W     = 31;
    localparam int ROOT_W    = 36;
    localparam int STEPS_W   = 7;
    localparam int FRAC_BITS = 20;
    localparam int MAX_STEPS = 64;

    // Guesses never exceed max(radicand/2, 2) in fixed point
    localparam int G_W    = RAD_W - 1 + FRAC_BITS;
    localparam int LO_W   = (G_W + 1) / 2;
    localparam int PROD_W = 2 * LO_W;
    localparam int NUM_W  = 2 * G_W + 1;
    localparam int D_W    = G_W + 1;
    localparam int DCNT_W = $clog2(D_W);
    localparam int SCNT_W = $clog2(MAX_STEPS + 1);
    localparam int STEPS_SAT = (1 << STEPS_W) - 1;
    localparam int STEPS_CAP_OUT = (MAX_STEPS > STEPS_SAT) ? STEPS_SAT : MAX_STEPS;

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] ADDR_WAIT = PC_W'(0);
    localparam logic [PC_W-1:0] ADDR_MUL  = PC_W'(2);
    localparam logic [PC_W-1:0] ADDR_DIV  = PC_W'(7);
    localparam logic [PC_W-1:0] ADDR_OUT  = PC_W'(10);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MLL,
        OP_MLH,
        OP_MHH,
        OP_ACC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_CHECK,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_TRIVIAL,
        C_CNT_NZ,
        C_EQ,
        C_BELOW_CAP,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic trivial;
        logic cnt_nz;
        logic eq;
        logic below_cap;
        logic out_busy;
    } t_status;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            4'd0:    w = '{OP_LOAD,     C_NO_IN,     ADDR_WAIT};
            4'd1:    w = '{OP_NONE,     C_TRIVIAL,   ADDR_OUT};
            4'd2:    w = '{OP_MLL,      C_NEVER,     ADDR_WAIT};
            4'd3:    w = '{OP_MLH,      C_NEVER,     ADDR_WAIT};
            4'd4:    w = '{OP_MHH,      C_NEVER,     ADDR_WAIT};
            4'd5:    w = '{OP_ACC,      C_NEVER,     ADDR_WAIT};
            4'd6:    w = '{OP_DIV_INIT, C_NEVER,     ADDR_WAIT};
            4'd7:    w = '{OP_DIV_STEP, C_CNT_NZ,    ADDR_DIV};
            4'd8:    w = '{OP_CHECK,    C_EQ,        ADDR_OUT};
            4'd9:    w = '{OP_NONE,     C_BELOW_CAP, ADDR_MUL};
            4'd10:   w = '{OP_OUT,      C_OUT_BUSY,  ADDR_OUT};
            4'd11:   w = '{OP_NONE,     C_ALWAYS,    ADDR_WAIT};
            default: w = '{OP_NONE,     C_ALWAYS,    ADDR_WAIT};
        endcase
        return w;
    endfunction

endpackage

[rtl/nsr_sequencer.sv]
// Microcode sequencer: step counter, program table and conditional jumps.
module nsr_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  nsr_pkg::t_status i_status,
    output nsr_pkg::t_op     o_op,
    output logic             o_idle
);
    import nsr_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          word;
    logic            take;

    assign word = ucode(r_pc);

    always_comb begin
        unique case (word.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_IN:     take = !i_in_valid;
            C_TRIVIAL:   take = i_status.trivial;
            C_CNT_NZ:    take = i_status.cnt_nz;
            C_EQ:        take = i_status.eq;
            C_BELOW_CAP: take = i_status.below_cap;
            C_OUT_BUSY:  take = i_status.out_busy;
            default:     take = 1'b0;
        endcase
    end

    // Wait-type steps hold without executing their operation
    always_comb begin
        if (take && (word.cond == C_NO_IN || word.cond == C_OUT_BUSY)) begin
            o_op = OP_NONE;
        end else begin
            o_op = word.op;
        end
    end

    assign n_pc   = take ? word.target : r_pc + PC_W'(1);
    assign o_idle = (r_pc == ADDR_WAIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ADDR_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[rtl/nsr_datapath.sv]
// Datapath: guess, split multiplier, numerator accumulator, restoring divider, result register.
module nsr_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nsr_pkg::t_op                  i_op,
    input  logic [nsr_pkg::RAD_W-1:0]     i_radicand,
    input  logic                          i_stall,
    output nsr_pkg::t_status              o_status,
    output logic                          o_valid,
    output logic [nsr_pkg::ROOT_W-1:0]    o_root,
    output logic [nsr_pkg::STEPS_W-1:0]   o_steps_used,
    output logic                          o_converged
);
    import nsr_pkg::*;

    logic [RAD_W-1:0]  r_n;
    logic [G_W-1:0]    r_g;
    logic              r_conv;
    logic [SCNT_W-1:0] r_steps;
    logic [PROD_W-1:0] r_prod;
    logic [NUM_W-1:0]  r_acc;
    logic [D_W-1:0]    r_rem;
    logic [D_W-1:0]    r_quo;
    logic [D_W-1:0]    r_div;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_out_valid;

    logic [LO_W-1:0]   g_lo;
    logic [LO_W-1:0]   g_hi;
    logic [LO_W-1:0]   mul_a;
    logic [LO_W-1:0]   mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [D_W:0]      trial;
    logic [D_W:0]      diff;
    logic              ge;
    logic              eq;

    assign g_lo = r_g[LO_W-1:0];
    assign g_hi = LO_W'(r_g[G_W-1:LO_W]);

    always_comb begin
        unique case (i_op)
            OP_MLL:  begin mul_a = g_lo; mul_b = g_lo; end
            OP_MLH:  begin mul_a = g_lo; mul_b = g_hi; end
            OP_MHH:  begin mul_a = g_hi; mul_b = g_hi; end
            default: begin mul_a = g_lo; mul_b = g_lo; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One restoring division step: shift in the next numerator bit, try subtract
    assign trial = {r_rem, r_quo[D_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = !diff[D_W];
    assign eq    = (r_quo == {1'b0, r_g});

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_n     <= i_radicand;
                r_conv  <= (i_radicand <= RAD_W'(1));
                r_steps <= '0;
                if (i_radicand <= RAD_W'(1)) begin
                    r_g <= G_W'(i_radicand) << FRAC_BITS;
                end else begin
                    r_g <= G_W'(i_radicand[RAD_W-1:1]) << FRAC_BITS;
                end
            end
            OP_MLL: begin
                r_prod <= mul_p;
                r_acc  <= (NUM_W'(r_n) << (2 * FRAC_BITS)) + NUM_W'(r_g);
            end
            OP_MLH: begin
                r_prod <= mul_p;
                r_acc  <= r_acc + NUM_W'(r_prod);
            end
            OP_MHH: begin
                // cross term appears twice: shift by one extra
                r_prod <= mul_p;
                r_acc  <= r_acc + (NUM_W'(r_prod) << (LO_W + 1));
            end
            OP_ACC: begin
                r_acc <= r_acc + (NUM_W'(r_prod) << (2 * LO_W));
            end
            OP_DIV_INIT: begin
                r_rem  <= D_W'(r_acc[NUM_W-1:D_W]);
                r_quo  <= r_acc[D_W-1:0];
                r_div  <= {r_g, 1'b0};
                r_dcnt <= DCNT_W'(D_W - 1);
            end
            OP_DIV_STEP: begin
                r_rem  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
                r_quo  <= {r_quo[D_W-2:0], ge};
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end
            OP_CHECK: begin
                r_steps <= r_steps + SCNT_W'(1);
                r_conv  <= eq;
                if (!eq) begin
                    r_g <= r_quo[G_W-1:0];
                end
            end
            OP_OUT: begin
                o_root       <= (|r_g[G_W-1:ROOT_W]) ? '1 : r_g[ROOT_W-1:0];
                o_steps_used <= (r_steps > SCNT_W'(STEPS_SAT)) ? '1 : STEPS_W'(r_steps);
                o_converged  <= r_conv;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status.trivial   = r_conv;
    assign o_status.cnt_nz    = (r_dcnt != '0);
    assign o_status.eq        = eq;
    assign o_status.below_cap = (r_steps < SCNT_W'(MAX_STEPS));
    assign o_status.out_busy  = r_out_valid && i_stall;

endmodule

[rtl/newton_square_root.sv]
// Radicands 0 and 1 go from the trivial check straight to the result register; other
// radicands run Newton steps until the guess stops changing or the step cap is hit.
// Each Newton step runs 4 multiply/accumulate steps on a 25x25 multiplier, a divider load,
// a restoring divide of 51 quotient bits and 2 check steps; a converging step skips the second.
// Throughput: one request at a time; the next is taken after the result is loaded,
// and the result register lets a new request start while the previous result waits.
// Reset (synchronous, active low) returns the sequencer to its wait step and drops o_valid.
module newton_square_root (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [nsr_pkg::RAD_W-1:0]     i_radicand,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [nsr_pkg::ROOT_W-1:0]    o_root,
    output logic [nsr_pkg::STEPS_W-1:0]   o_steps_used,
    output logic                          o_converged
);
    import nsr_pkg::*;

    t_op     op;
    t_status status;
    logic    idle;

    nsr_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_status   (status),
        .o_op       (op),
        .o_idle     (idle)
    );

    nsr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_radicand   (i_radicand),
        .i_stall      (i_stall),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_root       (o_root),
        .o_steps_used (o_steps_used),
        .o_converged  (o_converged)
    );

    assign o_stall = !idle;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted but input not stalled afterwards");

    a_cap_when_unconverged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_converged) |-> (o_steps_used == STEPS_W'(STEPS_CAP_OUT)))
        else $error("unconverged result without reaching the step cap");

    a_trivial_root_integer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_converged && o_steps_used == '0) |-> (o_root[FRAC_BITS-1:0] == '0))
        else $error("zero-step result carries fraction bits");
`endif

endmodule
